[design/das_pkg.sv]
package das_pkg;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_SUCC = 2'd1,
    OP_PRED = 2'd2,
    OP_NOP  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_LIST_FULL = 2'd3
  } status_t;

  localparam int KeyWidth = 32;

endpackage

[design/das_front.sv]
// Front end: a short registered item queue toward the back end.
module das_front #(
  parameter int QueueDepth = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   opcode,
  input  logic [das_pkg::KeyWidth-1:0] first_vertex,
  input  logic [das_pkg::KeyWidth-1:0] second_vertex,
  output logic                         q_valid,
  input  logic                         q_pop,
  output logic [1:0]                   q_opcode,
  output logic [das_pkg::KeyWidth-1:0] q_first,
  output logic [das_pkg::KeyWidth-1:0] q_second
);
  import das_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  logic [1:0]          op_q  [QueueDepth];
  logic [KeyWidth-1:0] a_q   [QueueDepth];
  logic [KeyWidth-1:0] b_q   [QueueDepth];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [PtrW:0]       count;
  logic                push;
  logic                pop;

  assign in_stall = (count == (PtrW+1)'(QueueDepth));
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && (count != '0);
  assign q_valid  = (count != '0);
  assign q_opcode = op_q[rd_ptr];
  assign q_first  = a_q[rd_ptr];
  assign q_second = b_q[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      op_q[wr_ptr] <= opcode;
      a_q[wr_ptr]  <= first_vertex;
      b_q[wr_ptr]  <= second_vertex;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end
endmodule

[design/das_back.sv]
// Back end: key lookup, list update and list readout.
module das_back #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_DEGREE   = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  output logic                         q_pop,
  input  logic [1:0]                   q_opcode,
  input  logic [das_pkg::KeyWidth-1:0] q_first,
  input  logic [das_pkg::KeyWidth-1:0] q_second,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   status,
  output logic [das_pkg::KeyWidth-1:0] neighbor,
  output logic                         neighbor_valid,
  output logic                         last,
  output logic [$clog2(MAX_VERTICES+1)-1:0] vertex_total
);
  import das_pkg::*;

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES+1);
  localparam int DW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int LW = $clog2(MAX_DEGREE+1);
  localparam int AW = VW + DW;

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_DECIDE, S_READ, S_EMIT, S_OUT
  } state_t;

  state_t state;

  logic [KeyWidth-1:0] vertex_keys [MAX_VERTICES];
  logic [LW-1:0]       succ_len    [MAX_VERTICES];
  logic [LW-1:0]       pred_len    [MAX_VERTICES];
  logic [KeyWidth-1:0] succ_mem    [2**AW];
  logic [KeyWidth-1:0] pred_mem    [2**AW];

  logic [CW-1:0]       fill;
  logic [1:0]          op;
  logic [KeyWidth-1:0] key_a;
  logic [KeyWidth-1:0] key_b;
  logic                hit_a, hit_b;
  logic [VW-1:0]       slot_a, slot_b;
  logic [LW-1:0]       rd_len;
  logic [DW-1:0]       rd_idx;
  logic                rd_pred;
  logic [KeyWidth-1:0] succ_rd, pred_rd;
  logic [LW-1:0]       succ_len_rd, pred_len_rd;

  // registered results of the parallel key compare
  logic                fa, fb;
  logic [VW-1:0]       sa, sb;

  // parallel compare against the registered keys
  always_comb begin
    hit_a  = 1'b0;
    hit_b  = 1'b0;
    slot_a = '0;
    slot_b = '0;
    for (int i = MAX_VERTICES-1; i >= 0; i--) begin
      if (CW'(i) < fill && vertex_keys[i] == key_a) begin
        hit_a  = 1'b1;
        slot_a = VW'(i);
      end
      if (CW'(i) < fill && vertex_keys[i] == key_b) begin
        hit_b  = 1'b1;
        slot_b = VW'(i);
      end
    end
  end

  // list memories, registered read
  always_ff @(posedge clk) begin
    succ_rd <= succ_mem[{sa, rd_idx}];
    pred_rd <= pred_mem[{sa, rd_idx}];
  end

  // list lengths, registered read at the compare result
  always_ff @(posedge clk) begin
    if (state == S_LOOK) begin
      succ_len_rd <= succ_len[slot_a];
      pred_len_rd <= pred_len[(op == OP_PRED) ? slot_a : slot_b];
    end
  end

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign out_valid = (state == S_OUT);

  // decision terms for an add
  logic [1:0]    need;
  logic [CW:0]   fill_need;
  logic [VW-1:0] new_a, new_b;
  logic          add_ok;
  logic [LW-1:0] succ_new, pred_new;
  always_comb begin
    need = 2'd0;
    if (!fa) need = need + 2'd1;
    if (!fb && !(!fa && key_a == key_b)) need = need + 2'd1;
    fill_need = {1'b0, fill} + (CW+1)'(need);
    new_a = fa ? sa : VW'(fill);
    if (fb) new_b = sb;
    else if (key_a == key_b) new_b = new_a;
    else new_b = VW'(fill + CW'(!fa));
    add_ok = (state == S_DECIDE) && (op == OP_ADD) &&
             (fill_need <= (CW+1)'(MAX_VERTICES)) &&
             !(fa && succ_len_rd >= LW'(MAX_DEGREE)) &&
             !(fb && pred_len_rd >= LW'(MAX_DEGREE));
    // fresh slots restart from one entry
    succ_new = (fa ? succ_len_rd : LW'(0)) + LW'(1);
    pred_new = (fb ? pred_len_rd : LW'(0)) + LW'(1);
  end

  // list and length writes of an accepted add
  always_ff @(posedge clk) begin
    if (add_ok) begin
      succ_mem[{new_a, DW'(fa ? succ_len_rd : LW'(0))}] <= key_b;
      pred_mem[{new_b, DW'(fb ? pred_len_rd : LW'(0))}] <= key_a;
      succ_len[new_a] <= succ_new;
      pred_len[new_b] <= pred_new;
      if (!fa && new_b != new_a) begin
        pred_len[new_a] <= '0;
      end
      if (!fb && new_b != new_a) begin
        succ_len[new_b] <= '0;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            op    <= q_opcode;
            key_a <= q_first;
            key_b <= q_second;
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          fa    <= hit_a;
          fb    <= hit_b;
          sa    <= slot_a;
          sb    <= slot_b;
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          neighbor       <= '0;
          neighbor_valid <= 1'b0;
          last           <= 1'b1;
          status         <= ST_OK;
          state          <= S_OUT;
          unique case (opcode_t'(op))
            OP_ADD: begin
              if (fill_need > (CW+1)'(MAX_VERTICES)) begin
                status <= ST_TABLE_FULL;
              end else if ((fa && succ_len_rd >= LW'(MAX_DEGREE)) ||
                           (fb && pred_len_rd >= LW'(MAX_DEGREE))) begin
                status <= ST_LIST_FULL;
              end else begin
                if (!fa) begin
                  vertex_keys[new_a] <= key_a;
                end
                if (!fb && key_a != key_b) begin
                  vertex_keys[new_b] <= key_b;
                end
                fill <= CW'(fill_need);
              end
            end
            OP_SUCC, OP_PRED: begin
              if (!fa) begin
                status <= ST_NOT_FOUND;
              end else begin
                rd_pred <= (op == OP_PRED);
                rd_len  <= (op == OP_PRED) ? pred_len_rd : succ_len_rd;
                rd_idx  <= '0;
                if (((op == OP_PRED) ? pred_len_rd : succ_len_rd) != '0) begin
                  state <= S_READ;
                end
              end
            end
            OP_NOP: ;
            default: ;
          endcase
        end
        S_READ: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          neighbor       <= rd_pred ? pred_rd : succ_rd;
          neighbor_valid <= 1'b1;
          status         <= ST_OK;
          last           <= ({1'b0, rd_idx} + (DW+1)'(1)) == (DW+1)'(rd_len);
          state          <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            if (!last) begin
              rd_idx <= rd_idx + 1'b1;
              state  <= S_READ;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign vertex_total = fill;
endmodule

[design/directed_adjacency_store_core.sv]
// Channel | Handshake          | Payload
// in      | in_valid/in_stall  | opcode, first_vertex, second_vertex
// out     | out_valid/out_stall| status, neighbor, neighbor_valid, last, vertex_total
//
// An add, a no-op, a failed lookup or an empty list holds the back end through S_LOOK,
// S_DECIDE and S_OUT, the last one presenting the result.
// A list query passes S_LOOK and S_DECIDE, then S_READ, S_EMIT and S_OUT per neighbor
// (read address, registered list read, output register).
// Synchronous reset clears the vertex count and the queue; a slot's list lengths
// are written when it is registered, so no clearing pass. A two-entry input
// queue keeps accepting until full while the back end waits; out_stall holds S_OUT.
module directed_adjacency_store_core #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_DEGREE   = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        opcode,
  input  logic signed [31:0]                first_vertex,
  input  logic signed [31:0]                second_vertex,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        status,
  output logic signed [31:0]                neighbor,
  output logic                              neighbor_valid,
  output logic                              last,
  output logic [$clog2(MAX_VERTICES+1)-1:0] vertex_total
);
  import das_pkg::*;

  logic                q_valid, q_pop;
  logic [1:0]          q_opcode;
  logic [KeyWidth-1:0] q_first, q_second;
  logic [KeyWidth-1:0] nb;

  das_front #(.QueueDepth(2)) u_front (
    .clk, .rst, .in_valid, .in_stall, .opcode,
    .first_vertex(first_vertex), .second_vertex(second_vertex),
    .q_valid, .q_pop, .q_opcode, .q_first, .q_second
  );

  das_back #(.MAX_VERTICES(MAX_VERTICES), .MAX_DEGREE(MAX_DEGREE)) u_back (
    .clk, .rst, .q_valid, .q_pop, .q_opcode, .q_first, .q_second,
    .out_valid, .out_stall, .status, .neighbor(nb), .neighbor_valid,
    .last, .vertex_total
  );

  assign neighbor = nb;
endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import das_pkg::*;

  localparam int MaxVerts  = 64;
  localparam int MaxDeg    = 32;
  localparam int CycleCap  = 900000;
  localparam int RandItems = 272;

  // one expected result item
  typedef struct packed {
    logic [1:0]  st;
    logic [31:0] nb;
    logic        nb_ok;
    logic        lst;
    logic [6:0]  total;
  } graph_reply_t;

  // stimulus row; chk_first marks a row whose last reply is typed in
  typedef struct {
    opcode_t      op;
    logic [31:0]  a;
    logic [31:0]  b;
    bit           chk_first;
    graph_reply_t want;
  } stim_row_t;

  logic clk, rst;
  logic in_valid, in_stall;
  logic [1:0] opcode;
  logic signed [31:0] first_vertex, second_vertex;
  logic out_valid, out_stall;
  logic [1:0] status;
  logic signed [31:0] neighbor;
  logic neighbor_valid, last;
  logic [6:0] vertex_total;

  directed_adjacency_store_core #(.MAX_VERTICES(MaxVerts), .MAX_DEGREE(MaxDeg)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .first_vertex(first_vertex), .second_vertex(second_vertex),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .neighbor(neighbor), .neighbor_valid(neighbor_valid),
    .last(last), .vertex_total(vertex_total)
  );

  // shadow graph
  logic [31:0] key_tab [MaxVerts];
  int          key_fill;
  logic [31:0] succ_tab [MaxVerts][MaxDeg];
  int          succ_len [MaxVerts];
  logic [31:0] pred_tab [MaxVerts][MaxDeg];
  int          pred_len [MaxVerts];

  graph_reply_t pending_replies[$];
  int mismatches = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit timed_out = 0;

  function automatic int lookup_key(logic [31:0] k);
    for (int i = 0; i < key_fill; i++)
      if (key_tab[i] == k) return i;
    return -1;
  endfunction

  function automatic graph_reply_t mk_reply(logic [1:0] st, logic [31:0] nb, logic v,
                                            logic l);
    graph_reply_t r;
    r.st = st; r.nb = nb; r.nb_ok = v; r.lst = l; r.total = key_fill[6:0];
    return r;
  endfunction

  function automatic void queue_reply(graph_reply_t x);
    pending_replies.insert(pending_replies.size(), x);
  endfunction

  // update the shadow graph and queue the replies this item causes
  function automatic void apply_graph_op(opcode_t op, logic [31:0] a, logic [31:0] b);
    int sa, sb, need, s, len;
    sa = lookup_key(a);
    sb = lookup_key(b);
    case (op)
      OP_ADD: begin
        need = (sa < 0) + ((sb < 0 && !(sa < 0 && a == b)) ? 1 : 0);
        if (key_fill + need > MaxVerts)
          queue_reply(mk_reply(ST_TABLE_FULL, 0, 0, 1));
        else if ((sa >= 0 && succ_len[sa] >= MaxDeg) || (sb >= 0 && pred_len[sb] >= MaxDeg))
          queue_reply(mk_reply(ST_LIST_FULL, 0, 0, 1));
        else begin
          if (sa < 0) begin
            sa = key_fill; key_tab[sa] = a; succ_len[sa] = 0; pred_len[sa] = 0;
            key_fill++;
          end
          if (sb < 0) begin
            if (a == b) sb = sa;
            else begin
              sb = key_fill; key_tab[sb] = b; succ_len[sb] = 0; pred_len[sb] = 0;
              key_fill++;
            end
          end
          succ_tab[sa][succ_len[sa]] = b; succ_len[sa]++;
          pred_tab[sb][pred_len[sb]] = a; pred_len[sb]++;
          queue_reply(mk_reply(ST_OK, 0, 0, 1));
        end
      end
      OP_NOP: queue_reply(mk_reply(ST_OK, 0, 0, 1));
      default: begin
        s = sa;
        if (s < 0) queue_reply(mk_reply(ST_NOT_FOUND, 0, 0, 1));
        else begin
          len = (op == OP_SUCC) ? succ_len[s] : pred_len[s];
          if (len == 0) queue_reply(mk_reply(ST_OK, 0, 0, 1));
          for (int j = 0; j < len; j++)
            queue_reply(mk_reply(ST_OK,
              (op == OP_SUCC) ? succ_tab[s][j] : pred_tab[s][j], 1, j + 1 == len));
        end
      end
    endcase
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleCap && !timed_out) begin
      timed_out = 1;
      $display("tb_top failed");
      $finish;
    end
  end

  // receiver stall
  initial out_stall = 1'b0;
  always @(negedge clk)
    out_stall <= ($urandom_range(99) < recv_stall_pct);

  // output checker
  always @(posedge clk) begin
    graph_reply_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got.st = status; got.nb = neighbor; got.nb_ok = neighbor_valid;
      got.lst = last; got.total = vertex_total;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", got);
      end else begin
        want = pending_replies.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: st %0d/%0d nb %h/%h v %b/%b last %b/%b total %0d/%0d",
                     want.st, got.st, want.nb, got.nb, want.nb_ok, got.nb_ok,
                     want.lst, got.lst, want.total, got.total);
        end
      end
    end
  end

  // drive one item and wait until it is accepted; valid stays up for the next one
  task automatic send_item(opcode_t op, logic [31:0] a, logic [31:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1; opcode <= op; first_vertex <= a; second_vertex <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_graph_op(op, a, b);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'h8000_0000 ^ $urandom_range(3);
      default: return $urandom_range(11);
    endcase
  endfunction

  stim_row_t rows[$];
  stim_row_t r;

  task automatic add_row(opcode_t op, logic [31:0] a, logic [31:0] b, bit chk,
                         graph_reply_t w);
    stim_row_t x;
    x.op = op; x.a = a; x.b = b; x.chk_first = chk; x.want = w;
    rows.insert(rows.size(), x);
  endtask

  function automatic graph_reply_t lit(logic [1:0] st, logic [6:0] tot);
    graph_reply_t w;
    w.st = st; w.nb = 0; w.nb_ok = 0; w.lst = 1; w.total = tot;
    return w;
  endfunction

  initial begin
    opcode_t op;
    logic [31:0] a, b;
    graph_reply_t w;
    rst = 1'b1; in_valid = 1'b0; opcode = OP_NOP; first_vertex = 0; second_vertex = 0;
    w = lit(ST_OK, 0);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    add_row(OP_SUCC, 32'h7fff_ffff, 0, 1, lit(ST_NOT_FOUND, 0));
    add_row(OP_PRED, 32'h8000_0000, 0, 1, lit(ST_NOT_FOUND, 0));
    add_row(OP_NOP, 32'hffff_ffff, 32'hffff_ffff, 1, lit(ST_OK, 0));
    add_row(OP_ADD, 32'h7fff_ffff, 32'h8000_0000, 1, lit(ST_OK, 2));
    add_row(OP_ADD, 32'h0, 32'h0, 1, lit(ST_OK, 3));
    add_row(OP_ADD, 32'hffff_ffff, 32'h7fff_ffff, 1, lit(ST_OK, 4));
    add_row(OP_ADD, 32'h7fff_ffff, 32'h8000_0000, 1, lit(ST_OK, 4));
    add_row(OP_SUCC, 32'h7fff_ffff, 0, 0, w);
    add_row(OP_PRED, 32'h7fff_ffff, 0, 0, w);
    add_row(OP_PRED, 32'h8000_0000, 0, 0, w);
    add_row(OP_SUCC, 32'h8000_0000, 0, 1, lit(ST_OK, 4));
    add_row(OP_SUCC, 32'h0, 0, 0, w);
    add_row(OP_PRED, 32'h0, 0, 0, w);
    // fill the predecessor list of key zero to the degree limit, then overflow
    for (int i = 0; i < MaxDeg - 1; i++) add_row(OP_ADD, 32'h5555_aaaa, 32'h0, 0, w);
    add_row(OP_ADD, 32'h5555_aaaa, 32'h0, 1, lit(ST_LIST_FULL, 5));
    add_row(OP_SUCC, 32'h5555_aaaa, 0, 0, w);
    // a full list rejects the add without registering the new source
    add_row(OP_ADD, 32'h1234, 32'h0, 1, lit(ST_LIST_FULL, 5));
    foreach (rows[i]) begin
      r = rows[i];
      send_item(r.op, r.a, r.b);
      if (r.chk_first && pending_replies[$] !== r.want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("table row %0d: expected %h predicted %h", i, r.want,
                   pending_replies[$]);
      end
    end

    // random phases
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 58 : (ph == 3) ? 26 : 0;
      recv_stall_pct = (ph == 2) ? 58 : (ph == 3) ? 26 : 0;
      for (int i = 0; i < RandItems / 4; i++) begin
        a = pick_key(); b = pick_key();
        case ($urandom_range(9))
          0, 1, 2, 3: op = OP_ADD;
          4, 5, 6: op = OP_SUCC;
          7, 8: op = OP_PRED;
          default: op = OP_NOP;
        endcase
        send_item(op, a, b);
      end
    end
    // fill the vertex table and push past it
    send_idle_pct = 10; recv_stall_pct = 10;
    for (int i = 0; i < 40; i++) send_item(OP_ADD, 32'h4000_0000 + 2 * i, 32'h4000_0001 + 2 * i);
    send_item(OP_ADD, 32'h6000_0000, 32'h4000_0000);
    send_item(OP_SUCC, 32'h4000_0000, 0);
    in_valid <= 1'b0;

    recv_stall_pct = 0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule

[sim.f]
design/das_pkg.sv
design/das_front.sv
design/das_back.sv
design/directed_adjacency_store_core.sv
tb/tb_top.sv
